@@ sv/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ESC   = 2'd1;
    localparam logic [1:0] ST_BAD_UTF8  = 2'd2;
    localparam logic [1:0] ST_TRUNC_ESC = 2'd3;

    typedef enum logic [2:0] {
        PH_PLAIN    = 3'd0,
        PH_BSL      = 3'd1,
        PH_HEX1     = 3'd2,
        PH_HEX2     = 3'd3,
        PH_HEX3     = 3'd4,
        PH_HEX4     = 3'd5,
        PH_PAIR_BSL = 3'd6,
        PH_PAIR_U   = 3'd7
    } ph_t;

    typedef enum logic [3:0] {
        U8_ACCEPT = 4'd0,
        U8_C1     = 4'd1,
        U8_C2     = 4'd2,
        U8_C3     = 4'd3,
        U8_E0     = 4'd4,
        U8_ED     = 4'd5,
        U8_F0     = 4'd6,
        U8_F4     = 4'd7,
        U8_REJECT = 4'd8
    } u8_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [1:0]  status;
        logic [31:0] byte_count;
        logic        run_last;
    } out_item_t;

    typedef struct packed {
        u8_t                   u8;
        ph_t                   phase;
        logic [15:0]           acc;
        logic [9:0]            hi;
        logic                  pend;
        logic [1:0]            err;
        logic [COUNT_BITS-1:0] wc;
    } dec_state_t;

    // results caused by one request: data bytes first, then optional status
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            has_status;
        logic [1:0]      status;
        logic [31:0]     count;
    } burst_t;

endpackage

`default_nettype wire

@@ sv/json_string_unescape_utf8.sv @@
// The first result of a request is presented in the cycle after acceptance.
// Throughput, with result_ready high: one request per cycle while each request
// yields at most one result; a request yielding k results (up to 5) holds the
// input while the single result register drains them, one result per cycle.
// Reset: rst_n asynchronous, active low; clears decoder state and drops any
// pending results. No memories, no clearing pass.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        item_valid,
    output logic       item_ready,
    input  var in_item_t item,
    output logic       result_valid,
    input  wire        result_ready,
    output out_item_t  result
);

    dec_state_t st_reg;
    dec_state_t st_next;
    burst_t     dec_burst;
    burst_t     burst_reg;
    logic       bvalid_reg;
    logic       bvalid_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       is_data;
    logic       out_last;
    logic       accept;
    logic       load;

    jsu_decode u_decode (
        .item  (item),
        .cur   (st_reg),
        .nxt   (st_next),
        .burst (dec_burst)
    );

    always_comb
    begin
        is_data           = idx_reg < burst_reg.nbytes;
        out_last          = is_data ? (idx_reg == burst_reg.nbytes - 3'd1 &&
                                       !burst_reg.has_status) : 1'b1;
        result_valid      = bvalid_reg;
        result.out_byte   = is_data ? burst_reg.bytes[idx_reg[1:0]] : 8'd0;
        result.is_status  = !is_data;
        result.status     = is_data ? ST_OK : burst_reg.status;
        result.byte_count = is_data ? 32'd0 : burst_reg.count;
        result.run_last   = out_last;
        item_ready        = !bvalid_reg || (result_ready && out_last);
        accept            = item_valid && item_ready;
        load              = accept && (dec_burst.nbytes != 3'd0 || dec_burst.has_status);
    end

    always_comb
    begin
        bvalid_next = bvalid_reg;
        idx_next    = idx_reg;
        if (bvalid_reg && result_ready)
        begin
            if (out_last)
            begin
                bvalid_next = 1'b0;
                idx_next    = 3'd0;
            end
            else
                idx_next = idx_reg + 3'd1;
        end
        if (load)
        begin
            bvalid_next = 1'b1;
            idx_next    = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.u8    <= U8_ACCEPT;
            st_reg.phase <= PH_PLAIN;
            st_reg.acc   <= '0;
            st_reg.hi    <= '0;
            st_reg.pend  <= 1'b0;
            st_reg.err   <= ST_OK;
            st_reg.wc    <= '0;
            bvalid_reg   <= 1'b0;
            idx_reg      <= 3'd0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            bvalid_reg <= bvalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= dec_burst;
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> (idx_reg < burst_reg.nbytes ||
                        (idx_reg == burst_reg.nbytes && burst_reg.has_status)))
        else $error("result index past end of burst");

    a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> (burst_reg.nbytes != 3'd0 || burst_reg.has_status))
        else $error("empty burst held as valid");

    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.pend && st_reg.err == ST_OK) |->
            (st_reg.phase != PH_PLAIN && st_reg.phase != PH_BSL))
        else $error("pending surrogate outside escape");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_string) |=>
            (st_reg.err == ST_OK && st_reg.phase == PH_PLAIN && st_reg.wc == '0))
        else $error("state not cleared at end of string");
`endif

endmodule

`default_nettype wire

@@ sv/jsu_decode.sv @@
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  var in_item_t   item,
    input  var dec_state_t cur,
    output dec_state_t     nxt,
    output burst_t         burst
);

    function automatic u8_t utf8_next(u8_t st, logic [7:0] b);
        u8_t r;
        r = U8_REJECT;
        case (st)
            U8_ACCEPT: begin
                if (b inside {[8'h00:8'h7F]}) r = U8_ACCEPT;
                else if (b inside {[8'hC2:8'hDF]}) r = U8_C1;
                else if (b == 8'hE0) r = U8_E0;
                else if (b == 8'hED) r = U8_ED;
                else if (b inside {[8'hE1:8'hEF]}) r = U8_C2;
                else if (b == 8'hF0) r = U8_F0;
                else if (b inside {[8'hF1:8'hF3]}) r = U8_C3;
                else if (b == 8'hF4) r = U8_F4;
            end
            U8_C1: if (b inside {[8'h80:8'hBF]}) r = U8_ACCEPT;
            U8_C2: if (b inside {[8'h80:8'hBF]}) r = U8_C1;
            U8_C3: if (b inside {[8'h80:8'hBF]}) r = U8_C2;
            U8_E0: if (b inside {[8'hA0:8'hBF]}) r = U8_C1;
            U8_ED: if (b inside {[8'h80:8'h9F]}) r = U8_C1;
            U8_F0: if (b inside {[8'h90:8'hBF]}) r = U8_C2;
            U8_F4: if (b inside {[8'h80:8'h8F]}) r = U8_C2;
            default: r = U8_REJECT;
        endcase
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
        else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    dec_state_t              s;
    logic [3:0][7:0]         bytes;
    logic [2:0]              nb;
    logic                    do_enc;
    logic [20:0]             cp;
    logic [4:0]              hx;
    logic [15:0]             v;
    u8_t                     u8n;
    logic [COUNT_BITS:0]     wc_sum;
    logic [COUNT_BITS-1:0]   wc_new;
    logic [63:0]             wc_wide;
    logic [1:0]              st;

    always_comb
    begin
        s      = cur;
        bytes  = '0;
        nb     = 3'd0;
        do_enc = 1'b0;
        cp     = '0;
        hx     = hex_value(item.in_byte);
        v      = {cur.acc[11:0], hx[3:0]};
        u8n    = utf8_next(cur.u8, item.in_byte);

        if (item.byte_present && cur.err == ST_OK)
        begin
            case (cur.phase)
                PH_PLAIN:
                begin
                    if (u8n == U8_REJECT)
                    begin
                        s.u8  = U8_ACCEPT;
                        s.err = ST_BAD_UTF8;
                    end
                    else
                    begin
                        s.u8 = u8n;
                        if (item.in_byte == 8'h5C)
                            s.phase = PH_BSL;
                        else
                        begin
                            bytes[0] = item.in_byte;
                            nb       = 3'd1;
                        end
                    end
                end
                PH_BSL:
                begin
                    s.phase = PH_PLAIN;
                    nb      = 3'd1;
                    case (item.in_byte)
                        8'h22, 8'h5C, 8'h2F: bytes[0] = item.in_byte;
                        8'h62: bytes[0] = 8'h08;
                        8'h66: bytes[0] = 8'h0C;
                        8'h6E: bytes[0] = 8'h0A;
                        8'h72: bytes[0] = 8'h0D;
                        8'h74: bytes[0] = 8'h09;
                        8'h75:
                        begin
                            nb      = 3'd0;
                            s.acc   = '0;
                            s.phase = PH_HEX1;
                        end
                        default:
                        begin
                            nb    = 3'd0;
                            s.err = ST_BAD_ESC;
                        end
                    endcase
                end
                PH_PAIR_BSL:
                begin
                    if (item.in_byte == 8'h5C) s.phase = PH_PAIR_U;
                    else s.err = ST_BAD_ESC;
                end
                PH_PAIR_U:
                begin
                    if (item.in_byte == 8'h75)
                    begin
                        s.acc   = '0;
                        s.phase = PH_HEX1;
                    end
                    else
                        s.err = ST_BAD_ESC;
                end
                default:
                begin
                    if (!hx[4])
                        s.err = ST_BAD_ESC;
                    else
                    begin
                        s.acc = v;
                        if (cur.phase != PH_HEX4)
                            s.phase = ph_t'(cur.phase + 3'd1);
                        else if (cur.pend)
                        begin
                            if (!(v inside {[16'hDC00:16'hDFFF]}))
                                s.err = ST_BAD_ESC;
                            else
                            begin
                                s.pend  = 1'b0;
                                cp      = 21'h10000 + 21'({cur.hi, v[9:0]});
                                do_enc  = 1'b1;
                                s.phase = PH_PLAIN;
                            end
                        end
                        else if (v inside {[16'hD800:16'hDBFF]})
                        begin
                            s.hi    = v[9:0];
                            s.pend  = 1'b1;
                            s.phase = PH_PAIR_BSL;
                        end
                        else if (v inside {[16'hDC00:16'hDFFF]})
                            s.err = ST_BAD_ESC;
                        else
                        begin
                            cp      = {5'd0, v};
                            do_enc  = 1'b1;
                            s.phase = PH_PLAIN;
                        end
                    end
                end
            endcase
        end

        if (do_enc)
        begin
            if (cp <= 21'h7F)
            begin
                bytes[0] = cp[7:0];
                nb       = 3'd1;
            end
            else if (cp <= 21'h7FF)
            begin
                bytes[0] = {3'b110, cp[10:6]};
                bytes[1] = {2'b10, cp[5:0]};
                nb       = 3'd2;
            end
            else if (cp <= 21'hFFFF)
            begin
                bytes[0] = {4'b1110, cp[15:12]};
                bytes[1] = {2'b10, cp[11:6]};
                bytes[2] = {2'b10, cp[5:0]};
                nb       = 3'd3;
            end
            else
            begin
                bytes[0] = {5'b11110, cp[20:18]};
                bytes[1] = {2'b10, cp[17:12]};
                bytes[2] = {2'b10, cp[11:6]};
                bytes[3] = {2'b10, cp[5:0]};
                nb       = 3'd4;
            end
        end

        // saturating count; at most four bytes per request
        wc_sum  = {1'b0, cur.wc} + (COUNT_BITS+1)'(nb);
        wc_new  = wc_sum[COUNT_BITS] ? '1 : wc_sum[COUNT_BITS-1:0];
        s.wc    = wc_new;
        wc_wide = 64'(wc_new);

        st = s.err;
        if (s.err == ST_OK)
        begin
            if (s.phase != PH_PLAIN) st = ST_TRUNC_ESC;
            else if (s.u8 != U8_ACCEPT) st = ST_BAD_UTF8;
        end

        burst.bytes      = bytes;
        burst.nbytes     = nb;
        burst.has_status = item.end_of_string;
        burst.status     = item.end_of_string ? st : ST_OK;
        burst.count      = (wc_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : wc_wide[31:0];

        nxt = s;
        if (item.end_of_string)
        begin
            nxt.u8    = U8_ACCEPT;
            nxt.phase = PH_PLAIN;
            nxt.acc   = '0;
            nxt.hi    = '0;
            nxt.pend  = 1'b0;
            nxt.err   = ST_OK;
            nxt.wc    = '0;
        end
    end

endmodule

`default_nettype wire

@@ bench/json_string_unescape_utf8_tb.sv @@
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam int         IDLE_PCT     = 38;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    json_string_unescape_utf8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // decoder model state
    u8_t                   m_utf8;
    ph_t                   m_phase;
    logic [15:0]           m_acc;
    logic [9:0]            m_hi;
    logic                  m_pend;
    logic [1:0]            m_err;
    logic [COUNT_BITS-1:0] m_count;

    out_item_t  expected_utf8[$];
    logic [7:0] string_bytes[$];
    bit         idle_on    = 1'b1;
    int         mismatches = 0;

    function automatic out_item_t make_result(logic [7:0] b, logic is_st, logic [1:0] st,
                                              logic [31:0] cnt);
        out_item_t r;
        r.out_byte   = b;
        r.is_status  = is_st;
        r.status     = st;
        r.byte_count = cnt;
        r.run_last   = 1'b0;
        return r;
    endfunction

    task automatic clear_decoder();
        m_utf8  = U8_ACCEPT;
        m_phase = PH_PLAIN;
        m_acc   = '0;
        m_hi    = '0;
        m_pend  = 1'b0;
        m_err   = ST_OK;
        m_count = '0;
    endtask

    function automatic u8_t utf8_advance(u8_t st, logic [7:0] b);
        case (st)
            U8_ACCEPT:
            begin
                if (b <= 8'h7F) return U8_ACCEPT;
                if (b >= 8'hC2 && b <= 8'hDF) return U8_C1;
                if (b == 8'hE0) return U8_E0;
                if (b == 8'hED) return U8_ED;
                if (b >= 8'hE1 && b <= 8'hEF) return U8_C2;
                if (b == 8'hF0) return U8_F0;
                if (b >= 8'hF1 && b <= 8'hF3) return U8_C3;
                if (b == 8'hF4) return U8_F4;
                return U8_REJECT;
            end
            U8_C1: return (b >= 8'h80 && b <= 8'hBF) ? U8_ACCEPT : U8_REJECT;
            U8_C2: return (b >= 8'h80 && b <= 8'hBF) ? U8_C1 : U8_REJECT;
            U8_C3: return (b >= 8'h80 && b <= 8'hBF) ? U8_C2 : U8_REJECT;
            U8_E0: return (b >= 8'hA0 && b <= 8'hBF) ? U8_C1 : U8_REJECT;
            U8_ED: return (b >= 8'h80 && b <= 8'h9F) ? U8_C1 : U8_REJECT;
            U8_F0: return (b >= 8'h90 && b <= 8'hBF) ? U8_C2 : U8_REJECT;
            U8_F4: return (b >= 8'h80 && b <= 8'h8F) ? U8_C2 : U8_REJECT;
            default: return U8_REJECT;
        endcase
    endfunction

    function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] enc);
        enc = '0;
        if (cp <= 21'h7F) begin
            enc[0] = cp[7:0];
            return 1;
        end
        else if (cp <= 21'h7FF) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            return 2;
        end
        else if (cp <= 21'hFFFF) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            return 3;
        end
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    task automatic emit_octet(logic [7:0] b);
        expected_utf8.push_back(make_result(b, 1'b0, ST_OK, 32'd0));
        if (m_count != '1)
            m_count = m_count + 1'b1;
    endtask

    task automatic emit_code_point(logic [20:0] cp);
        logic [3:0][7:0] enc;
        int              n;
        n = utf8_encode(cp, enc);
        for (int i = 0; i < n; i++)
            emit_octet(enc[i]);
    endtask

    function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
        v = '0;
        if (b >= "0" && b <= "9") v = 4'(b - "0");
        else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
        else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
        else return 1'b0;
        return 1'b1;
    endfunction

    task automatic finish_code_unit();
        bit is_high;
        bit is_low;
        is_high = m_acc >= 16'hD800 && m_acc <= 16'hDBFF;
        is_low  = m_acc >= 16'hDC00 && m_acc <= 16'hDFFF;
        if (m_pend) begin
            if (!is_low) begin
                m_err = ST_BAD_ESC;
            end
            else begin
                m_pend = 1'b0;
                emit_code_point(21'h10000 + {1'b0, m_hi, m_acc[9:0]});
                m_phase = PH_PLAIN;
            end
        end
        else if (is_high) begin
            m_hi    = m_acc[9:0];
            m_pend  = 1'b1;
            m_phase = PH_PAIR_BSL;
        end
        else if (is_low) begin
            m_err = ST_BAD_ESC;
        end
        else begin
            emit_code_point({5'd0, m_acc});
            m_phase = PH_PLAIN;
        end
    endtask

    task automatic absorb_octet(logic [7:0] b);
        logic [3:0] v;
        case (m_phase)
            PH_PLAIN:
            begin
                m_utf8 = utf8_advance(m_utf8, b);
                if (m_utf8 == U8_REJECT) begin
                    m_utf8 = U8_ACCEPT;
                    m_err  = ST_BAD_UTF8;
                end
                else if (b == CH_BACKSLASH) begin
                    m_phase = PH_BSL;
                end
                else begin
                    emit_octet(b);
                end
            end
            PH_BSL:
            begin
                m_phase = PH_PLAIN;
                if (b == CH_QUOTE || b == CH_BACKSLASH || b == CH_SLASH) emit_octet(b);
                else if (b == "b") emit_octet(8'h08);
                else if (b == "f") emit_octet(8'h0C);
                else if (b == "n") emit_octet(8'h0A);
                else if (b == "r") emit_octet(8'h0D);
                else if (b == "t") emit_octet(8'h09);
                else if (b == "u") begin
                    m_acc   = '0;
                    m_phase = PH_HEX1;
                end
                else m_err = ST_BAD_ESC;
            end
            PH_PAIR_BSL:
            begin
                if (b == CH_BACKSLASH) m_phase = PH_PAIR_U;
                else m_err = ST_BAD_ESC;
            end
            PH_PAIR_U:
            begin
                if (b == "u") begin
                    m_acc   = '0;
                    m_phase = PH_HEX1;
                end
                else m_err = ST_BAD_ESC;
            end
            default:
            begin
                if (!hex_nibble(b, v)) begin
                    m_err = ST_BAD_ESC;
                end
                else begin
                    m_acc = {m_acc[11:0], v};
                    if (m_phase != PH_HEX4) m_phase = ph_t'(m_phase + 3'd1);
                    else finish_code_unit();
                end
            end
        endcase
    endtask

    task automatic decode_request(in_item_t r);
        int        n0;
        logic [1:0] st;
        out_item_t tail;
        n0 = expected_utf8.size();
        if (r.byte_present && m_err == ST_OK)
            absorb_octet(r.in_byte);
        if (r.end_of_string) begin
            st = m_err;
            if (st == ST_OK) begin
                if (m_phase != PH_PLAIN) st = ST_TRUNC_ESC;
                else if (m_utf8 != U8_ACCEPT) st = ST_BAD_UTF8;
            end
            expected_utf8.push_back(make_result(8'h00, 1'b1, st, 32'(m_count)));
            clear_decoder();
        end
        if (expected_utf8.size() > n0) begin
            tail = expected_utf8[expected_utf8.size() - 1];
            tail.run_last = 1'b1;
            expected_utf8[expected_utf8.size() - 1] = tail;
        end
    endtask

    task automatic send_request(in_item_t r);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        do @(posedge clk); while (!item_ready);
        decode_request(r);
    endtask

    // sends string_bytes; end flag on the last byte or on a bare end marker
    task automatic send_string(bit bare_end, int absent_pct);
        int n;
        n = string_bytes.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < absent_pct)
                send_request('{in_byte: 8'($urandom_range(255)), byte_present: 1'b0,
                               end_of_string: 1'b0});
            send_request('{in_byte: string_bytes[i], byte_present: 1'b1,
                           end_of_string: (!bare_end && i == n - 1)});
        end
        if (bare_end || n == 0)
            send_request('{in_byte: 8'($urandom_range(255)), byte_present: 1'b0,
                           end_of_string: 1'b1});
    endtask

    task automatic load_text(string s);
        string_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            string_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    task automatic push_u_escape(logic [15:0] unit, int ndigits);
        string_bytes.push_back(CH_BACKSLASH);
        string_bytes.push_back("u");
        for (int i = 0; i < ndigits; i++)
            string_bytes.push_back(hex_char(unit[15 - 4 * i -: 4]));
    endtask

    function automatic logic [15:0] random_bmp();
        logic [15:0] cp;
        cp = 16'($urandom_range(16'hFFFF));
        if (cp >= 16'hD800 && cp <= 16'hDFFF)
            cp = cp - 16'h0800;
        return cp;
    endfunction

    task automatic gen_token();
        int              kind;
        logic [20:0]     cp;
        logic [3:0][7:0] enc;
        int              n;
        logic [7:0]      b;
        kind = $urandom_range(99);
        if (kind < 30) begin
            do b = 8'($urandom_range(127)); while (b == CH_BACKSLASH);
            string_bytes.push_back(b);
        end
        else if (kind < 45) begin
            case ($urandom_range(2))
                0: cp = 21'($urandom_range(16'h80, 16'h7FF));
                1: cp = {5'd0, random_bmp()};
                default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            endcase
            if (cp < 21'h800 && cp[15:0] > 16'h7FF) cp = 21'h800;
            if (cp < 21'h80) cp = cp + 21'h80;
            n = utf8_encode(cp, enc);
            for (int i = 0; i < n; i++)
                string_bytes.push_back(enc[i]);
        end
        else if (kind < 60) begin
            string_bytes.push_back(CH_BACKSLASH);
            case ($urandom_range(7))
                0: string_bytes.push_back(CH_QUOTE);
                1: string_bytes.push_back(CH_BACKSLASH);
                2: string_bytes.push_back(CH_SLASH);
                3: string_bytes.push_back("b");
                4: string_bytes.push_back("f");
                5: string_bytes.push_back("n");
                6: string_bytes.push_back("r");
                default: string_bytes.push_back("t");
            endcase
        end
        else if (kind < 75) begin
            push_u_escape(random_bmp(), 4);
        end
        else if (kind < 85) begin
            push_u_escape(16'hD800 + 16'($urandom_range(10'h3FF)), 4);
            push_u_escape(16'hDC00 + 16'($urandom_range(10'h3FF)), 4);
        end
        else begin
            case ($urandom_range(4))
                0: string_bytes.push_back(8'($urandom_range(255)));
                1: push_u_escape(16'hD800 + 16'($urandom_range(10'h3FF)), 4);
                2: push_u_escape(16'hDC00 + 16'($urandom_range(10'h3FF)), 4);
                3:
                begin
                    string_bytes.push_back(CH_BACKSLASH);
                    string_bytes.push_back(8'($urandom_range(255)));
                end
                default:
                begin
                    push_u_escape(random_bmp(), $urandom_range(3));
                    if ($urandom_range(1)) string_bytes.push_back("g");
                end
            endcase
        end
    endtask

    task automatic test_empty_and_raw();
        send_request('{in_byte: 8'h00, byte_present: 1'b0, end_of_string: 1'b1});
        send_request('{in_byte: 8'h00, byte_present: 1'b1, end_of_string: 1'b0});
        send_request('{in_byte: 8'hFF, byte_present: 1'b0, end_of_string: 1'b0});
        send_request('{in_byte: 8'h7F, byte_present: 1'b1, end_of_string: 1'b0});
        // invalid lead byte, then everything ignored
        send_request('{in_byte: 8'hFF, byte_present: 1'b1, end_of_string: 1'b0});
        send_request('{in_byte: CH_BACKSLASH, byte_present: 1'b1, end_of_string: 1'b1});
    endtask

    task automatic test_escape_left_open();
        load_text("\\t\\/\\u07FF\\");
        send_string(1'b0, 0);
    endtask

    task automatic test_surrogate_pair();
        load_text("\\udbff\\uDFFF");
        send_string(1'b0, 0);
    endtask

    task automatic test_lone_low_surrogate();
        load_text("\\uDC00");
        send_string(1'b0, 0);
    endtask

    task automatic test_incomplete_utf8();
        string_bytes = '{8'hF0, 8'h90};
        send_string(1'b0, 0);
    endtask

    task automatic test_random_strings(int n_items);
        int sent;
        int ntok;
        bit bare;
        sent = 0;
        while (sent < n_items) begin
            string_bytes.delete();
            ntok = $urandom_range(6);
            for (int i = 0; i < ntok; i++)
                gen_token();
            bare = ($urandom_range(99) < 30) || string_bytes.size() == 0;
            sent += string_bytes.size() + (bare ? 1 : 0);
            send_string(bare, 8);
        end
    endtask

    task automatic test_no_stall_stream();
        idle_on = 1'b0;
        test_random_strings(45);
        idle_on = 1'b1;
    endtask

    always @(negedge clk)
        result_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_utf8.size() == 0) begin
                $error("unexpected result: out_byte %0h is_status %0b status %0d",
                       result.out_byte, result.is_status, result.status);
                mismatches++;
            end
            else begin
                want = expected_utf8.pop_front();
                if (result.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, result.out_byte);
                    mismatches++;
                end
                if (result.is_status !== want.is_status) begin
                    $error("is_status: expected %0b, actual %0b", want.is_status,
                           result.is_status);
                    mismatches++;
                end
                if (result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    mismatches++;
                end
                if (result.byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, actual %0d", want.byte_count,
                           result.byte_count);
                    mismatches++;
                end
                if (result.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, actual %0b", want.run_last, result.run_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_raw();
        test_escape_left_open();
        test_surrogate_pair();
        test_lone_low_surrogate();
        test_incomplete_utf8();
        test_random_strings(115);
        test_no_stall_stream();

        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_utf8.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/json_string_unescape_utf8.sv
bench/json_string_unescape_utf8_tb.sv
